// ----- rtl/mm4_pkg.sv -----
package mm4_pkg;

  localparam int DIM         = 4;
  localparam int ROW_W       = 2;
  localparam int ELEM_W_DEF  = 32;
  localparam int FRAC_W_DEF  = 16;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DIM - 1);

  typedef enum logic {
    ST_LOAD,
    ST_ISSUE
  } mm4_state_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             issue;
    logic [ROW_W-1:0] issue_row;
  } mm4_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic adv;
  } mm4_status_t;

endpackage

// ----- rtl/mm4_ctrl.sv -----
module mm4_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [mm4_pkg::ROW_W-1:0] in_row,
  output logic                      in_ready,
  input  mm4_pkg::mm4_status_t      status,
  output mm4_pkg::mm4_cmd_t         cmd
);
  import mm4_pkg::*;

  mm4_state_t       state, state_next;
  logic [ROW_W-1:0] issue_row, issue_row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      issue_row <= '0;
    end else begin
      state     <= state_next;
      issue_row <= issue_row_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && in_row == LAST_ROW) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (status.adv && issue_row == LAST_ROW) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.issue      = 1'b0;
    cmd.issue_row  = issue_row;
    issue_row_next = issue_row;
    unique case (state)
      ST_LOAD: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid;
        issue_row_next = '0;
      end
      ST_ISSUE: begin
        cmd.issue = status.adv;
        if (status.adv) issue_row_next = issue_row + ROW_W'(1);
      end
      default: begin
        issue_row_next = '0;
      end
    endcase
  end

endmodule

// ----- rtl/mm4_datapath.sv -----
module mm4_datapath #(
  parameter int ELEM_WIDTH = mm4_pkg::ELEM_W_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mm4_pkg::mm4_cmd_t           cmd,
  output mm4_pkg::mm4_status_t        status,
  input  logic [mm4_pkg::ROW_W-1:0]   wr_row,
  input  logic [ELEM_WIDTH-1:0]       a_in [mm4_pkg::DIM],
  input  logic [ELEM_WIDTH-1:0]       b_in [mm4_pkg::DIM],
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [mm4_pkg::ROW_W-1:0]   res_row,
  output logic [ELEM_WIDTH-1:0]       res_col [mm4_pkg::DIM]
);
  import mm4_pkg::*;

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int SW = PW + 2;

  logic signed [ELEM_WIDTH-1:0] a_st [DIM][DIM];
  logic signed [ELEM_WIDTH-1:0] b_st [DIM][DIM];

  logic signed [PW-1:0]   prod [DIM][DIM];
  logic signed [PW:0]     pair [DIM][2];
  logic signed [SW-1:0]   total [DIM];
  logic signed [SW-1:0]   shifted [DIM];
  logic [ELEM_WIDTH-1:0]  sat [DIM];

  logic                   v1, v2;
  logic [ROW_W-1:0]       row1, row2;
  logic                   adv;

  assign adv        = !res_valid || res_ready;
  assign status.adv = adv;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < DIM; k++) begin
        a_st[wr_row][k] <= a_in[k];
        b_st[wr_row][k] <= b_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= cmd.issue;
      v2        <= v1;
      res_valid <= v2;
    end
  end

  // stage 1: sixteen products, C[r][c] term k = A[r][k] * B[k][c]
  always_ff @(posedge clk) begin
    if (adv) begin
      row1 <= cmd.issue_row;
      for (int c = 0; c < DIM; c++) begin
        for (int k = 0; k < DIM; k++) begin
          prod[c][k] <= a_st[cmd.issue_row][k] * b_st[k][c];
        end
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (adv) begin
      row2 <= row1;
      for (int c = 0; c < DIM; c++) begin
        pair[c][0] <= (PW+1)'(prod[c][0]) + (PW+1)'(prod[c][1]);
        pair[c][1] <= (PW+1)'(prod[c][2]) + (PW+1)'(prod[c][3]);
      end
    end
  end

  // stage 3: final sum, floor shift, saturate
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      total[c]   = SW'(pair[c][0]) + SW'(pair[c][1]);
      shifted[c] = total[c] >>> FRAC_BITS;
      if (&shifted[c][SW-1:ELEM_WIDTH-1] || ~|shifted[c][SW-1:ELEM_WIDTH-1]) begin
        sat[c] = shifted[c][ELEM_WIDTH-1:0];
      end else if (shifted[c][SW-1]) begin
        sat[c] = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
      end else begin
        sat[c] = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_row <= row2;
      for (int c = 0; c < DIM; c++) res_col[c] <= sat[c];
    end
  end

endmodule

// ----- rtl/matrix_multiply_4x4.sv -----
// channel   dir  tdata (low bit up)                  tuser       tlast
// s_axis    in   a_col0..a_col3, b_col0..b_col3      row_index   -
// m_axis    out  c_col0..c_col3                      out_row     last_row
//
// One load item per cycle while the input is open; the row 3 item starts the
// product. The four product rows are then issued in turn through 16
// multipliers; results pass the product, pair-sum and output registers.
// rst is synchronous, active high. A stall on m_axis freezes the pipeline;
// row 0..2 items of the next pair are taken while results drain.
module matrix_multiply_4x4 #(
  parameter int ELEM_WIDTH = mm4_pkg::ELEM_W_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_W_DEF,
  localparam int IN_W      = ((2 * mm4_pkg::DIM * ELEM_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((mm4_pkg::DIM * ELEM_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_W-1:0]           s_axis_tdata,   // a_col0..a_col3, b_col0..b_col3
  input  logic [mm4_pkg::ROW_W-1:0] s_axis_tuser,   // row_index
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,   // c_col0..c_col3
  output logic [mm4_pkg::ROW_W-1:0] m_axis_tuser,   // out_row
  output logic                      m_axis_tlast    // last_row
);
  import mm4_pkg::*;

  mm4_cmd_t                cmd;
  mm4_status_t             status;
  logic [ELEM_WIDTH-1:0]   a_in [DIM];
  logic [ELEM_WIDTH-1:0]   b_in [DIM];
  logic [ELEM_WIDTH-1:0]   res_col [DIM];
  logic [DIM*ELEM_WIDTH-1:0] res_flat;

  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      a_in[k] = s_axis_tdata[k*ELEM_WIDTH +: ELEM_WIDTH];
      b_in[k] = s_axis_tdata[(DIM+k)*ELEM_WIDTH +: ELEM_WIDTH];
    end
    for (int c = 0; c < DIM; c++) res_flat[c*ELEM_WIDTH +: ELEM_WIDTH] = res_col[c];
  end

  assign m_axis_tdata = OUT_W'(res_flat);
  assign m_axis_tlast = (m_axis_tuser == LAST_ROW);

  mm4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_row   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mm4_datapath #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .wr_row    (s_axis_tuser),
    .a_in      (a_in),
    .b_in      (b_in),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_row   (m_axis_tuser),
    .res_col   (res_col)
  );

endmodule

// ----- rtl/mm4_checker.sv -----
module mm4_checker #(
  parameter int OUT_W = 128
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [mm4_pkg::ROW_W-1:0] s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_W-1:0]          m_axis_tdata,
  input logic [mm4_pkg::ROW_W-1:0] m_axis_tuser,
  input logic                      m_axis_tlast
);
  import mm4_pkg::*;

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // last item of a product is row 3
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == LAST_ROW)))
    else $error("tlast does not match row 3");

  // row 3 load closes the input until the product is issued
  a_close: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser == LAST_ROW) |=> !s_axis_tready)
    else $error("input open after row 3");

  // product rows follow one another without gaps
  a_rows: assert property (@(posedge clk) disable iff (rst)
    (out_acc && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + ROW_W'(1)))
    else $error("product row out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_4x4 mm4_checker #(
  .OUT_W (OUT_W)
) u_mm4_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/matrix_multiply_4x4_tb.sv -----
module matrix_multiply_4x4_tb;
  import mm4_pkg::*;

  localparam int ELEM_W          = ELEM_W_DEF;
  localparam int FRAC_W          = FRAC_W_DEF;
  localparam int ACC_W           = 2 * ELEM_W + 4;
  localparam int IN_BITS         = ((2 * DIM * ELEM_W + 7) / 8) * 8;
  localparam int OUT_BITS        = ((DIM * ELEM_W + 7) / 8) * 8;
  localparam int NUM_ITEMS       = 280;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam logic [ELEM_W-1:0] Q_ONE   = ELEM_W'(1) << FRAC_W;
  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic [DIM-1:0][ELEM_W-1:0] elem_row_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    elem_row_t        col;
    logic             last;
  } product_row_t;

  class matmul_scoreboard;
    logic signed [ELEM_W-1:0] left_elems[DIM*DIM];
    logic signed [ELEM_W-1:0] right_elems[DIM*DIM];
    product_row_t pending_products[$];
    int mismatches;
    int rows_checked;
    int loads;
    int clipped;

    function logic [ELEM_W-1:0] shift_saturate(logic signed [ACC_W-1:0] sum);
      logic signed [ACC_W-1:0] sat_hi;
      logic signed [ACC_W-1:0] sat_lo;
      logic signed [ACC_W-1:0] shifted;
      sat_hi = {{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
      sat_lo = ~sat_hi;
      shifted = sum >>> FRAC_W;
      if (shifted > sat_hi) begin
        clipped++;
        return ELEM_MAX;
      end
      if (shifted < sat_lo) begin
        clipped++;
        return ELEM_MIN;
      end
      return shifted[ELEM_W-1:0];
    endfunction

    // row 3 triggers the whole product from whatever the stores hold
    function void load_row(logic [ROW_W-1:0] row, elem_row_t a, elem_row_t b);
      logic signed [ACC_W-1:0] acc;
      product_row_t pr;
      loads++;
      for (int c = 0; c < DIM; c++) begin
        left_elems[row*DIM+c]  = a[c];
        right_elems[row*DIM+c] = b[c];
      end
      if (row != LAST_ROW) return;
      for (int r = 0; r < DIM; r++) begin
        pr.row  = ROW_W'(r);
        pr.last = (r == DIM - 1);
        for (int c = 0; c < DIM; c++) begin
          acc = '0;
          for (int k = 0; k < DIM; k++)
            acc = acc + left_elems[r*DIM+k] * right_elems[k*DIM+c];
          pr.col[c] = shift_saturate(acc);
        end
        pending_products.push_back(pr);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_product_row(logic [ROW_W-1:0] row, elem_row_t col, logic last);
      product_row_t want;
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("product row %0d arrived with nothing pending", row));
        return;
      end
      want = pending_products.pop_front();
      rows_checked++;
      if (row !== want.row)
        report_mismatch($sformatf("out_row %0d, want %0d", row, want.row));
      for (int c = 0; c < DIM; c++)
        if (col[c] !== want.col[c])
          report_mismatch($sformatf("row %0d col %0d: got %h, want %h",
                                    want.row, c, col[c], want.col[c]));
      if (last !== want.last)
        report_mismatch($sformatf("row %0d: last_row %b, want %b", want.row, last, want.last));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata;   // a_col0..a_col3, b_col0..b_col3
  logic [ROW_W-1:0]    s_axis_tuser;   // row_index
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_BITS-1:0] m_axis_tdata;   // c_col0..c_col3
  logic [ROW_W-1:0]    m_axis_tuser;   // out_row
  logic                m_axis_tlast;   // last_row

  matmul_scoreboard sb = new();
  int  items_sent;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_off_req;
  bit  hold_off_issued;
  int  quiet_cycles;

  matrix_multiply_4x4 uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0, 1: return ELEM_W'($urandom);
      2, 3: return ELEM_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      4: return ELEM_W'(int'($urandom_range(0, 64)) - 32);
      5: return ELEM_MAX;
      6: return ELEM_MIN;
      default: return ELEM_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic elem_row_t rand_row();
    elem_row_t v;
    for (int c = 0; c < DIM; c++) v[c] = rand_elem();
    return v;
  endfunction

  task automatic offer_item(input logic [ROW_W-1:0] row, input elem_row_t a,
                            input elem_row_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_BITS'({b, a});
    s_axis_tuser  = row;
    do @(posedge clk); while (!s_axis_tready);
    sb.load_row(row, a, b);
    items_sent++;
  endtask

  task automatic offer_filled(input logic [ROW_W-1:0] row, input logic [ELEM_W-1:0] av,
                              input logic [ELEM_W-1:0] bv);
    offer_item(row, {DIM{av}}, {DIM{bv}});
  endtask

  task automatic offer_matrix_pair();
    for (int r = 0; r < DIM; r++) offer_item(ROW_W'(r), rand_row(), rand_row());
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_issued) begin
        hold_off_issued = 1'b1;
        m_axis_tready   = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_product_row(m_axis_tuser, elem_row_t'(m_axis_tdata[DIM*ELEM_W-1:0]),
                           m_axis_tlast);
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    elem_row_t a;
    rst             = 1'b1;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    items_sent      = 0;
    hold_off_req    = 1'b0;
    tx_idle_pct     = 17;
    rx_idle_pct     = 60;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity on the left: product equals the right matrix
    for (int r = 0; r < DIM; r++) begin
      a    = '0;
      a[r] = Q_ONE;
      offer_item(ROW_W'(r), a, rand_row());
    end
    // positive overflow
    for (int r = 0; r < DIM; r++) offer_filled(ROW_W'(r), ELEM_MAX, ELEM_MAX);
    // rows out of order, negative overflow
    offer_filled(ROW_W'(2), ELEM_MIN, ELEM_MAX);
    offer_filled(ROW_W'(0), ELEM_MIN, ELEM_MAX);
    offer_filled(ROW_W'(1), ELEM_MIN, ELEM_MAX);
    offer_filled(LAST_ROW, ELEM_MIN, ELEM_MAX);
    // most negative times itself, then row 3 repeated on stored rows
    offer_filled(ROW_W'(1), ELEM_MIN, ELEM_MIN);
    offer_filled(LAST_ROW, ELEM_MIN, ELEM_MIN);
    offer_filled(LAST_ROW, ELEM_MAX, ELEM_MIN);
    // tiny negative sums: shift rounds towards minus infinity
    for (int r = 0; r < DIM; r++) offer_filled(ROW_W'(r), '1, ELEM_W'(1));
    offer_filled(ROW_W'(0), '0, '0);
    offer_filled(LAST_ROW, ELEM_W'(1), '1);

    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= 200) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (!hold_off_req && items_sent >= 220) hold_off_req = 1'b1;
      end else if (items_sent >= 120) begin
        tx_idle_pct = 60;
        rx_idle_pct = 17;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: offer_matrix_pair();
        7: repeat ($urandom_range(1, 3))
             offer_item(ROW_W'($urandom_range(0, 2)), rand_row(), rand_row());
        8: offer_item(ROW_W'($urandom_range(0, 3)), rand_row(), rand_row());
        default: begin
          offer_matrix_pair();
          offer_item(LAST_ROW, rand_row(), rand_row());
        end
      endcase
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d row loads and %0d product rows, %0d elements clipped,",
             sb.loads, sb.rows_checked, sb.clipped);
    $display("with both-side stalls and a %0d-cycle output hold-off; %0d mismatches",
             HOLD_OFF_CYCLES, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
